// ----- src/nearest_centroid_classifier_core_defines.svh -----
// assertion macros for the nearest centroid classifier core
// needs i_clk and i_rst_n in the scope where the macros are used
`ifndef NEAREST_CENTROID_CLASSIFIER_CORE_DEFINES_SVH
`define NEAREST_CENTROID_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ncc_pkg.sv -----
// shared widths, codes and reset values for the nearest centroid classifier
// no dependencies
`timescale 1ns / 1ps

package ncc_pkg;

    // payload widths
    localparam int VAL_W      = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 38;
    localparam int BEST_W     = 4;
    localparam int CIDX_W     = 4;
    localparam int DIDX_W     = 5;

    // configuration registers
    localparam int NCL_W      = 5;
    localparam int NDIM_W     = 6;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [NCL_W-1:0]  NCL_RST  = NCL_W'(16);
    localparam logic [NDIM_W-1:0] NDIM_RST = NDIM_W'(32);

    // default sizes of the stores
    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int DEF_MAX_DIMS     = 32;

    // saturation ceiling of a partial distance
    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    // input beat commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_FEATURE = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CLUSTERS = 1'b0,
        CFG_NUM_DIMS     = 1'b1
    } t_cfg_idx;

endpackage

// ----- src/ncc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ncc_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 512,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ncc_accum.sv -----
// squared-difference accumulate and running minimum over the clusters of one element
// depends on ncc_pkg; works on read data from the centroid and distance rams
`timescale 1ns / 1ps

module ncc_accum
    import ncc_pkg::*;
#(
    parameter int  MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    localparam int CW           = $clog2(MAX_CLUSTERS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_row_start,
    input  logic                    i_issue_vld,
    input  logic [CW-1:0]           i_issue_idx,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic signed [VAL_W-1:0] i_cen_rdata,
    input  logic [DIST_W-1:0]       i_pd_rdata,
    output logic                    o_pd_we,
    output logic [CW-1:0]           o_pd_waddr,
    output logic [DIST_W-1:0]       o_pd_wdata,
    output logic                    o_busy,
    output logic [CW-1:0]           o_best_idx,
    output logic [DIST_W-1:0]       o_min_dist
);

    // pipeline control
    logic                    r_p1, r_p2, r_p3;
    logic [MAX_CLUSTERS-1:0] r_vld;

    // pipeline payload
    logic [CW-1:0]     r_j1, r_j2, r_j3;
    logic [SQ_W-1:0]   r_sq;
    logic [DIST_W-1:0] r_pd_old;
    logic [DIST_W-1:0] r_sum;
    logic [DIST_W-1:0] r_min;
    logic [CW-1:0]     r_best;

    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]        diff_neg;
    logic [MAG_W-1:0]      mag;
    logic [SQ_W-1:0]       sq;
    logic [DIST_W:0]       sum_wide;
    logic [DIST_W-1:0]     sum_sat;

    // first stage: exact difference and its square
    always_comb begin
        diff     = {i_value[VAL_W-1], i_value} - {i_cen_rdata[VAL_W-1], i_cen_rdata};
        diff_neg = -diff;
        mag      = MAG_W'(diff[VAL_W] ? diff_neg : diff);
        sq       = {{(SQ_W-MAG_W){1'b0}}, mag} * {{(SQ_W-MAG_W){1'b0}}, mag};
    end

    // second stage: saturating add onto the partial distance
    always_comb begin
        sum_wide = {1'b0, r_pd_old} + (DIST_W+1)'(r_sq);
        sum_sat  = sum_wide[DIST_W] ? DIST_SAT : sum_wide[DIST_W-1:0];
    end

    // control: stage valids and per-cluster written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1  <= 1'b0;
            r_p2  <= 1'b0;
            r_p3  <= 1'b0;
            r_vld <= '0;
        end else begin
            r_p1 <= i_issue_vld;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            if (i_row_start) begin
                r_vld <= '0;
            end else if (r_p2) begin
                r_vld[r_j2] <= 1'b1;
            end
        end
    end

    // payload through the stages
    always_ff @(posedge i_clk) begin
        r_j1     <= i_issue_idx;
        r_j2     <= r_j1;
        r_j3     <= r_j2;
        r_sq     <= sq;
        r_pd_old <= r_vld[r_j1] ? i_pd_rdata : '0;
        r_sum    <= sum_sat;
    end

    // third stage: running minimum, strict less-than keeps the lowest index
    always_ff @(posedge i_clk) begin
        if (r_p3 && ((r_j3 == '0) || (r_sum < r_min))) begin
            r_min  <= r_sum;
            r_best <= r_j3;
        end
    end

    assign o_pd_we    = r_p2;
    assign o_pd_waddr = r_j2;
    assign o_pd_wdata = sum_sat;
    assign o_busy     = r_p1 | r_p2 | r_p3;
    assign o_best_idx = r_best;
    assign o_min_dist = r_min;

endmodule

// ----- src/nearest_centroid_classifier_core.sv -----
// k-means assignment: nearest centroid search with a centroid ram and a distance ram
// depends on ncc_pkg, ncc_ram, ncc_accum and the assertion macro header
//
//  channel  direction  handshake           payload
//  in       input      i_valid / o_ready   i_cmd, i_cluster_index, i_dim_index, i_value
//  out      output     o_valid / i_ready   o_best_cluster, o_min_distance
//  cfg      input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// a centroid load keeps the block ready; a feature element is swept over all k clusters,
// k being the active cluster count, with one ram read per cluster through a three-stage
// square and accumulate pipeline, and the next beat is accepted once the pipeline drains.
// synchronous active-low reset; partial distances use per-cluster flags, so no clearing pass.
// a row result waits in the output register; only a finishing row stalls behind it.
`timescale 1ns / 1ps

`include "nearest_centroid_classifier_core_defines.svh"

module nearest_centroid_classifier_core
    import ncc_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = DEF_MAX_DIMS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input beats
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_cmd,
    input  logic [CIDX_W-1:0]       i_cluster_index,
    input  logic [DIDX_W-1:0]       i_dim_index,
    input  logic signed [VAL_W-1:0] i_value,
    // result beats
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [BEST_W-1:0]       o_best_cluster,
    output logic [DIST_W-1:0]       o_min_distance,
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW   = $clog2(MAX_CLUSTERS);
    localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNTW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS + 1) : 1;
    localparam int CEN_DEPTH = MAX_CLUSTERS * (2 ** DW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state              r_state;
    logic [NCL_W-1:0]    r_num_clusters;
    logic [NDIM_W-1:0]   r_num_dims;
    logic [CNTW-1:0]     r_cnt;
    logic [CW-1:0]       r_j;
    logic [DW-1:0]       r_dim;
    logic                r_last;
    logic signed [VAL_W-1:0] r_value;
    logic                r_out_vld;
    logic [BEST_W-1:0]   r_out_best;
    logic [DIST_W-1:0]   r_out_dist;

    logic                in_acc;
    logic                is_feature;
    logic                load_ok;
    logic                row_start;
    logic                row_end;
    logic [CNTW:0]       cnt_inc;
    logic [CW-1:0]       k_m1;
    logic [NDIM_W-1:0]   d_act;
    logic                out_free;
    logic                out_load;

    logic                cen_we;
    logic [CW+DW-1:0]    cen_waddr;
    logic signed [VAL_W-1:0] cen_rdata;
    logic                pd_we;
    logic [CW-1:0]       pd_waddr;
    logic [DIST_W-1:0]   pd_wdata;
    logic [DIST_W-1:0]   pd_rdata;
    logic                acc_busy;
    logic [CW-1:0]       acc_best;
    logic [DIST_W-1:0]   acc_min;

    // active cluster and dimension counts, zero raised to one and clamped to the store sizes
    always_comb begin
        if (r_num_clusters == '0) begin
            k_m1 = '0;
        end else if (32'(r_num_clusters) > 32'(MAX_CLUSTERS)) begin
            k_m1 = CW'(MAX_CLUSTERS - 1);
        end else begin
            k_m1 = CW'(r_num_clusters - NCL_W'(1));
        end
        if (r_num_dims == '0) begin
            d_act = NDIM_W'(1);
        end else if (32'(r_num_dims) > 32'(MAX_DIMS)) begin
            d_act = NDIM_W'(MAX_DIMS);
        end else begin
            d_act = r_num_dims;
        end
    end

    // input beat decode
    assign o_ready    = (r_state == ST_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign is_feature = (i_cmd == CMD_FEATURE);
    assign load_ok    = (32'(i_cluster_index) < 32'(MAX_CLUSTERS)) &&
                        (32'(i_dim_index) < 32'(MAX_DIMS));
    assign cnt_inc    = {1'b0, r_cnt} + (CNTW+1)'(1);
    assign row_end    = (32'(cnt_inc) >= 32'(d_act));
    assign row_start  = in_acc && is_feature && (r_cnt == '0);
    assign out_free   = !r_out_vld || i_ready;
    assign out_load   = (r_state == ST_DRAIN) && !acc_busy && r_last && out_free;

    // centroid writes go straight to the ram on accept
    assign cen_we    = in_acc && !is_feature && load_ok;
    assign cen_waddr = {CW'(i_cluster_index), DW'(i_dim_index)};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_clusters <= NCL_RST;
            r_num_dims     <= NDIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_CLUSTERS: r_num_clusters <= NCL_W'(i_cfg_data);
                CFG_NUM_DIMS:     r_num_dims     <= NDIM_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // sequencer: one element at a time, one cluster read per cycle, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_j       <= '0;
            r_dim     <= '0;
            r_last    <= 1'b0;
            r_value   <= '0;
            r_out_vld <= 1'b0;
            r_out_best <= '0;
            r_out_dist <= '0;
        end else begin
            // result register: load a finished row, clear once taken
            if (out_load) begin
                r_out_vld  <= 1'b1;
                r_out_best <= BEST_W'(acc_best);
                r_out_dist <= acc_min;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && is_feature) begin
                        r_value <= i_value;
                        r_dim   <= DW'(r_cnt);
                        r_last  <= row_end;
                        r_cnt   <= row_end ? '0 : CNTW'(cnt_inc);
                        r_j     <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_j == k_m1) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!acc_busy && (!r_last || out_free)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // centroid store
    ncc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CEN_DEPTH)
    ) u_cen_ram (
        .i_clk   (i_clk),
        .i_we    (cen_we),
        .i_waddr (cen_waddr),
        .i_wdata (i_value),
        .i_raddr ({r_j, r_dim}),
        .o_rdata (cen_rdata)
    );

    // partial distance store
    ncc_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_pd_ram (
        .i_clk   (i_clk),
        .i_we    (pd_we),
        .i_waddr (pd_waddr),
        .i_wdata (pd_wdata),
        .i_raddr (r_j),
        .o_rdata (pd_rdata)
    );

    // square, accumulate and minimum pipeline
    ncc_accum #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_start (row_start),
        .i_issue_vld (r_state == ST_RUN),
        .i_issue_idx (r_j),
        .i_value     (r_value),
        .i_cen_rdata (cen_rdata),
        .i_pd_rdata  (pd_rdata),
        .o_pd_we     (pd_we),
        .o_pd_waddr  (pd_waddr),
        .o_pd_wdata  (pd_wdata),
        .o_busy      (acc_busy),
        .o_best_idx  (acc_best),
        .o_min_dist  (acc_min)
    );

    assign o_valid        = r_out_vld;
    assign o_best_cluster = r_out_best;
    assign o_min_distance = r_out_dist;

    // checks on the sequencer
    `NCC_ASSERT_NOW(a_idle_pipe_empty, o_ready, !acc_busy, "pipeline busy while taking beats")
    `NCC_ASSERT_NOW(a_cnt_range, 1'b1, 32'(r_cnt) < 32'(MAX_DIMS), "element counter out of range")
    `NCC_ASSERT_NEXT(a_run_end, (r_state == ST_RUN) && (r_j == k_m1), r_state == ST_DRAIN, "cluster sweep overran")
    `NCC_ASSERT_NEXT(a_row_result, (r_state == ST_DRAIN) && !acc_busy && r_last && out_free, r_out_vld, "row result dropped")

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for nearest_centroid_classifier_core
// depends on ncc_pkg and the core; holds its own nearest-centroid predictor
`timescale 1ns / 1ps

module tb;
    import ncc_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int IDLE_WAIT    = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_PHASE   = 2;
    localparam int RANDOM_BEATS = 1070;

    typedef struct packed {
        logic [BEST_W-1:0] best;
        logic [DIST_W-1:0] dsq;
    } t_label;

    typedef struct packed {
        bit                      is_cfg;
        t_cfg_idx                reg_idx;
        logic [CFG_DATA_W-1:0]   reg_data;
        logic                    cmd;
        logic [CIDX_W-1:0]       cidx;
        logic [DIDX_W-1:0]       didx;
        logic signed [VAL_W-1:0] val;
        bit                      typed;
        t_label                  want;
    } t_step;

    // block ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_cmd = CMD_LOAD;
    logic [CIDX_W-1:0]       i_cluster_index = '0;
    logic [DIDX_W-1:0]       i_dim_index = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [BEST_W-1:0]       o_best_cluster;
    logic [DIST_W-1:0]       o_min_distance;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = CFG_NUM_CLUSTERS;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // predictor state
    logic signed [VAL_W-1:0] centroid_mem [DEF_MAX_CLUSTERS][DEF_MAX_DIMS];
    logic [DIST_W-1:0]       row_dist [DEF_MAX_CLUSTERS] = '{default: '0};
    int unsigned             row_pos = 0;
    logic [NCL_W-1:0]        cluster_cfg = NCL_RST;
    logic [NDIM_W-1:0]       dim_cfg = NDIM_RST;

    t_label      pending_labels [$];
    int unsigned err_count = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    bit          quiet = 1'b0;

    nearest_centroid_classifier_core dut (.*);

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // clamped register values, as the block applies them
    function automatic int unsigned active_clusters();
        if (cluster_cfg == 0) return 1;
        if (cluster_cfg > DEF_MAX_CLUSTERS) return DEF_MAX_CLUSTERS;
        return cluster_cfg;
    endfunction

    function automatic int unsigned active_dims();
        if (dim_cfg == 0) return 1;
        if (dim_cfg > DEF_MAX_DIMS) return DEF_MAX_DIMS;
        return dim_cfg;
    endfunction

    // one input beat through the predictor; returns 1 when a row finishes
    function automatic bit classify_beat(input logic cmd, input logic [CIDX_W-1:0] cidx,
                                         input logic [DIDX_W-1:0] didx,
                                         input logic signed [VAL_W-1:0] val,
                                         output t_label lab);
        int unsigned     k, d, pos, j;
        int              diff;
        longint unsigned sq, acc;
        lab = '0;
        k   = active_clusters();
        d   = active_dims();
        if (cmd == CMD_LOAD) begin
            centroid_mem[cidx][didx] = val;
            return 1'b0;
        end
        // fresh row clears every partial sum
        if (row_pos == 0) begin
            foreach (row_dist[n]) row_dist[n] = '0;
        end
        pos = (row_pos >= DEF_MAX_DIMS) ? DEF_MAX_DIMS - 1 : row_pos;
        for (j = 0; j < k; j++) begin
            diff = int'(val) - int'(centroid_mem[j][pos]);
            sq   = (diff < 0) ? longint'(-diff) : longint'(diff);
            acc  = longint'(row_dist[j]) + sq * sq;
            row_dist[j] = (acc > longint'(DIST_SAT)) ? DIST_SAT : DIST_W'(acc);
        end
        row_pos++;
        if (row_pos < d) return 1'b0;
        row_pos = 0;
        // strict less-than keeps the lowest index on ties
        lab.best = '0;
        lab.dsq  = row_dist[0];
        for (j = 1; j < k; j++) begin
            if (row_dist[j] < lab.dsq) begin
                lab.dsq  = row_dist[j];
                lab.best = BEST_W'(j);
            end
        end
        return 1'b1;
    endfunction

    // offer one beat, wait for the handshake, then record what it should produce
    task automatic send_beat(input logic cmd, input logic [CIDX_W-1:0] cidx,
                             input logic [DIDX_W-1:0] didx,
                             input logic signed [VAL_W-1:0] val,
                             input bit typed = 1'b0, input t_label typed_lab = '0);
        t_label lab;
        if (!quiet && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_cluster_index <= cidx;
        i_dim_index     <= didx;
        i_value         <= val;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (classify_beat(cmd, cidx, didx, val, lab))
            pending_labels.push_back(typed ? typed_lab : lab);
    endtask

    // register write once every result is in and the pipeline has drained
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (pending_labels.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NUM_CLUSTERS) cluster_cfg = data[NCL_W-1:0];
        else dim_cfg = data;
    endtask

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_ready   <= 1'b0;
        end else if (quiet) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 20);
        end
    end

    task automatic flag_result(input string what, input t_label want, input t_label got);
        err_count++;
        if (err_count <= 10)
            $display("result %0d %s: expected best %0d dist %0d, got best %0d dist %0d",
                     results_seen, what, want.best, want.dsq, got.best, got.dsq);
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_label got, want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            got.best = o_best_cluster;
            got.dsq  = o_min_distance;
            if (pending_labels.size() == 0) begin
                flag_result("unexpected", '0, got);
            end else begin
                want = pending_labels.pop_front();
                if (got.best !== want.best || got.dsq !== want.dsq)
                    flag_result("mismatch", want, got);
            end
            results_seen++;
        end
    end

    // directed plan builders
    function automatic t_step cfg_step(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_step s = '0;
        s.is_cfg   = 1'b1;
        s.reg_idx  = idx;
        s.reg_data = data;
        return s;
    endfunction

    function automatic t_step load_step(input int c, input int e,
                                        input logic signed [VAL_W-1:0] v);
        t_step s = '0;
        s.cmd  = CMD_LOAD;
        s.cidx = CIDX_W'(c);
        s.didx = DIDX_W'(e);
        s.val  = v;
        return s;
    endfunction

    function automatic t_step feat_step(input logic signed [VAL_W-1:0] v);
        t_step s = '0;
        s.cmd  = CMD_FEATURE;
        s.cidx = CIDX_W'($urandom);
        s.didx = DIDX_W'($urandom);
        s.val  = v;
        return s;
    endfunction

    function automatic t_step feat_known(input logic signed [VAL_W-1:0] v,
                                         input int best, input longint dsq);
        t_step s = feat_step(v);
        s.typed     = 1'b1;
        s.want.best = BEST_W'(best);
        s.want.dsq  = DIST_W'(dsq);
        return s;
    endfunction

    initial begin
        t_step                   plan [$];
        int unsigned             beats, phase, span, r, i, c, e, src, dst, pos;
        logic [CIDX_W-1:0]       cidx;
        logic [DIDX_W-1:0]       didx;
        logic signed [VAL_W-1:0] v;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole centroid store so no unwritten entry is ever read
        for (c = 0; c < DEF_MAX_CLUSTERS; c++) begin
            for (e = 0; e < DEF_MAX_DIMS; e++) begin
                r = $urandom_range(99);
                v = (r < 10) ? 16'sh7fff : (r < 20) ? 16'sh8000 : VAL_W'($urandom);
                send_beat(CMD_LOAD, CIDX_W'(c), DIDX_W'(e), v);
            end
        end

        // two clusters, one dimension: ties, extremes, exact squares
        plan.push_back(cfg_step(CFG_NUM_CLUSTERS, 6'd2));
        plan.push_back(cfg_step(CFG_NUM_DIMS, 6'd1));
        plan.push_back(load_step(0, 0, 16'sh0000));
        plan.push_back(load_step(1, 0, 16'sh0000));
        plan.push_back(feat_known(16'sh0000, 0, 0));
        plan.push_back(load_step(0, 0, 16'sh8000));
        plan.push_back(load_step(1, 0, 16'sh7fff));
        plan.push_back(feat_known(16'sh7fff, 1, 0));
        plan.push_back(feat_known(16'sh8000, 0, 0));
        plan.push_back(feat_known(16'sh0000, 1, 64'd1073676289));
        plan.push_back(load_step(0, 0, -16'sd5));
        plan.push_back(load_step(1, 0, 16'sd5));
        plan.push_back(feat_known(16'sh0000, 0, 25));
        // zero dimensions clamps to one
        plan.push_back(cfg_step(CFG_NUM_DIMS, 6'd0));
        plan.push_back(feat_step(16'sh7fff));
        // zero clusters clamps to one, then registers and centroids change mid-row
        plan.push_back(cfg_step(CFG_NUM_CLUSTERS, 6'd32));
        plan.push_back(cfg_step(CFG_NUM_DIMS, 6'd3));
        plan.push_back(feat_step(16'sh0100));
        plan.push_back(load_step(15, 1, 16'sh7fff));
        plan.push_back(feat_step(16'sh7fff));
        plan.push_back(cfg_step(CFG_NUM_CLUSTERS, 6'd31));
        plan.push_back(cfg_step(CFG_NUM_DIMS, 6'd2));
        plan.push_back(feat_step(16'sh8000));
        plan.push_back(load_step(15, 31, 16'sh5a5a));
        plan.push_back(cfg_step(CFG_NUM_DIMS, 6'd63));

        foreach (plan[n]) begin
            if (plan[n].is_cfg)
                cfg_write(plan[n].reg_idx, plan[n].reg_data);
            else
                send_beat(plan[n].cmd, plan[n].cidx, plan[n].didx, plan[n].val,
                          plan[n].typed, plan[n].want);
        end

        // random phases, each with its own register setting
        beats = 0;
        phase = 0;
        while (beats < RANDOM_BEATS) begin
            if (phase == HOLD_PHASE) begin
                // short rows pile up behind a stalled receiver
                cfg_write(CFG_NUM_CLUSTERS, 6'd2);
                cfg_write(CFG_NUM_DIMS, 6'd1);
                hold_req <= 1'b1;
                span = 90;
            end else begin
                r = $urandom_range(99);
                cfg_write(CFG_NUM_CLUSTERS,
                          (r < 20) ? 6'd16 : (r < 30) ? 6'd1 : (r < 35) ? 6'd0 :
                          (r < 40) ? CFG_DATA_W'($urandom_range(17, 63)) :
                          CFG_DATA_W'($urandom_range(2, 15)));
                r = $urandom_range(99);
                cfg_write(CFG_NUM_DIMS,
                          (r < 45) ? CFG_DATA_W'($urandom_range(1, 4)) :
                          (r < 70) ? CFG_DATA_W'($urandom_range(5, 12)) :
                          (r < 80) ? 6'd32 : (r < 85) ? 6'd0 : (r < 90) ? 6'd63 :
                          CFG_DATA_W'($urandom_range(13, 31)));
                span = $urandom_range(40, 90);
            end
            quiet <= (phase >= 6 && phase < 9);

            for (i = 0; i < span; i++) begin
                r   = $urandom_range(99);
                pos = (row_pos >= DEF_MAX_DIMS) ? DEF_MAX_DIMS - 1 : row_pos;
                if (r < 3) begin
                    // duplicate a whole centroid to force distance ties
                    src = $urandom_range(active_clusters() - 1);
                    dst = $urandom_range(active_clusters() - 1);
                    for (e = 0; e < active_dims(); e++)
                        send_beat(CMD_LOAD, CIDX_W'(dst), DIDX_W'(e), centroid_mem[src][e]);
                    beats += active_dims();
                end else if (r < 15) begin
                    cidx = CIDX_W'($urandom);
                    didx = $urandom_range(1) ? DIDX_W'(pos) : DIDX_W'($urandom);
                    v    = $urandom_range(99) < 30 ?
                           centroid_mem[$urandom_range(DEF_MAX_CLUSTERS - 1)][didx] :
                           VAL_W'($urandom);
                    send_beat(CMD_LOAD, cidx, didx, v);
                    beats++;
                end else begin
                    r = $urandom_range(99);
                    if (r < 10) v = 16'sh7fff;
                    else if (r < 20) v = 16'sh8000;
                    else if (r < 45)
                        v = VAL_W'(int'(centroid_mem[$urandom_range(active_clusters() - 1)][pos])
                                   + int'($urandom_range(6)) - 3);
                    else v = VAL_W'($urandom);
                    send_beat(CMD_FEATURE, CIDX_W'($urandom), DIDX_W'($urandom), v);
                    beats++;
                end
            end
            phase++;
        end

        // drain
        i_valid <= 1'b0;
        while (pending_labels.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (err_count == 0 && pending_labels.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
